@@ rtl/bpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bipartite matching check package
// Shared widths, constants, sequencer states and scan result type.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int NUM_COLS         = 16;
  localparam int COL_W            = 4;
  localparam int NEXT_W           = 5;
  localparam int ROW_W            = 16;
  localparam int CFG_W            = 5;
  localparam int MATCH_W          = 5;
  localparam int MAX_SIZE_DEFAULT = 16;
  localparam int STACK_DEPTH      = NUM_COLS + 1;
  localparam int DEPTH_W          = 5;
  localparam int STK_ENTRIES      = NUM_COLS;
  localparam int STK_AW           = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd14;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW_START,
    ST_SCAN,
    ST_POP_LOAD,
    ST_COMMIT,
    ST_ROW_DONE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] col;
  } scan_result_t;

endpackage
`default_nettype wire

@@ rtl/bpm_intf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bipartite matching check channels
// Row input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bpm_row_if;
  logic                       valid;
  logic                       ready;
  logic [bpm_pkg::ROW_W-1:0]  adjacency_row;
  logic                       row_last;

  modport source (output valid, output adjacency_row, output row_last, input ready);
  modport sink (input valid, input adjacency_row, input row_last, output ready);
endinterface

interface bpm_result_if;
  logic                        valid;
  logic                        ready;
  logic                        all_matched;
  logic [bpm_pkg::MATCH_W-1:0] rows_matched;
  logic                        too_many_rows;

  modport source (output valid, output all_matched, output rows_matched,
                  output too_many_rows, input ready);
  modport sink (input valid, input all_matched, input rows_matched,
                input too_many_rows, output ready);
endinterface

interface bpm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bpm_pkg::CFG_W-1:0] columns_in_use;

  modport source (output valid, output columns_in_use, input ready);
  modport sink (input valid, input columns_in_use, output ready);
endinterface
`default_nettype wire

@@ rtl/bpm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bpm_col_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Column scan unit
// Finds the lowest usable, unvisited column at or above the resume point.
// ----------------------------------------------------------------------------
module bpm_col_scan (
  input  wire logic [bpm_pkg::ROW_W-1:0]  adj,
  input  wire logic [bpm_pkg::ROW_W-1:0]  visited,
  input  wire logic [bpm_pkg::NEXT_W-1:0] start,
  input  wire logic [bpm_pkg::CFG_W-1:0]  cols_in_use,
  output      bpm_pkg::scan_result_t      res
);

  logic [bpm_pkg::NUM_COLS-1:0] cand;

  always_comb begin
    for (int i = 0; i < bpm_pkg::NUM_COLS; i++) begin
      cand[i] = adj[i] && !visited[i] && (5'(i) >= start) && (5'(i) < cols_in_use);
    end
    res = '0;
    for (int i = bpm_pkg::NUM_COLS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.found = 1'b1;
        res.col   = bpm_pkg::COL_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bipartite_perfect_matching_check_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bipartite perfect matching check unit
// Stores adjacency rows, then runs augmenting-path matching row by row.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle while the unit is in its load state. After the
// last row, each row runs a start step that reads it from the row store, then
// column scan steps for each chosen column or pop, a reload step for each
// popped frame and, on success, a write-back step for each stacked frame.
// The result is held in an output register. Synchronous reset clears control
// state, the row count, column ownership valid bits and column count to 14.
// ----------------------------------------------------------------------------
module bipartite_perfect_matching_check_unit #(
  parameter int MAX_SIZE = bpm_pkg::MAX_SIZE_DEFAULT
) (
  input wire logic     clk,
  input wire logic     rst,
  bpm_row_if.sink      rows,
  bpm_result_if.source result,
  bpm_cfg_if.sink      cfg
);

  localparam int ROW_IDX_W = $clog2(MAX_SIZE);
  localparam int CNT_W     = $clog2(MAX_SIZE + 1);
  localparam int STK_W     = ROW_IDX_W + bpm_pkg::NEXT_W;

  bpm_pkg::state_t state, state_next;

  logic [bpm_pkg::CFG_W-1:0]   cols_in_use;
  logic [CNT_W-1:0]            row_count;
  logic                        overflow;
  logic [ROW_IDX_W-1:0]        cur_row;
  logic [bpm_pkg::DEPTH_W-1:0] depth;
  logic [ROW_IDX_W-1:0]        top_row;
  logic [bpm_pkg::NEXT_W-1:0]  top_next;
  logic [bpm_pkg::ROW_W-1:0]   visited;
  logic [ROW_IDX_W-1:0]        owner [bpm_pkg::NUM_COLS];
  logic [bpm_pkg::NUM_COLS-1:0] owner_valid;
  logic [bpm_pkg::STK_AW-1:0]  commit_idx;
  logic                        res_all;
  logic [bpm_pkg::MATCH_W-1:0] res_matched;
  logic                        res_tmr;
  logic                        out_valid;
  logic                        out_all;
  logic [bpm_pkg::MATCH_W-1:0] out_matched;
  logic                        out_tmr;

  logic                        row_accept;
  logic                        room;
  logic                        row_we;
  logic                        row_re;
  logic [ROW_IDX_W-1:0]        row_raddr;
  logic [bpm_pkg::ROW_W-1:0]   row_rdata;
  logic                        stk_we;
  logic [bpm_pkg::STK_AW-1:0]  stk_waddr;
  logic [STK_W-1:0]            stk_wdata;
  logic                        stk_re;
  logic [bpm_pkg::STK_AW-1:0]  stk_raddr;
  logic [STK_W-1:0]            stk_rdata;
  logic [ROW_IDX_W-1:0]        frame_row;
  logic [bpm_pkg::NEXT_W-1:0]  frame_next;
  logic [bpm_pkg::COL_W-1:0]   frame_col;
  logic                        load_out;
  logic                        last_row;
  logic [5:0]                  cur_row6;
  logic [5:0]                  row_count6;
  logic [bpm_pkg::NEXT_W-1:0]  col_next;
  bpm_pkg::scan_result_t       scan;

  assign rows.ready   = (state == bpm_pkg::ST_LOAD);
  assign cfg.ready    = 1'b1;
  assign row_accept   = rows.valid && rows.ready;
  assign room         = (row_count < CNT_W'(MAX_SIZE));
  assign row_we       = row_accept && room;
  assign frame_row    = stk_rdata[STK_W-1:bpm_pkg::NEXT_W];
  assign frame_next   = stk_rdata[bpm_pkg::NEXT_W-1:0];
  assign frame_col    = bpm_pkg::COL_W'(frame_next - 5'd1);
  assign last_row     = ((CNT_W'(cur_row) + CNT_W'(1)) == row_count);
  assign cur_row6     = 6'(cur_row);
  assign row_count6   = 6'(row_count);
  assign col_next     = bpm_pkg::NEXT_W'(scan.col) + 5'd1;

  assign result.valid         = out_valid;
  assign result.all_matched   = out_all;
  assign result.rows_matched  = out_matched;
  assign result.too_many_rows = out_tmr;

  bpm_ram #(
    .WIDTH (bpm_pkg::ROW_W),
    .DEPTH (MAX_SIZE),
    .ADDR_W(ROW_IDX_W)
  ) u_row_store (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_count[ROW_IDX_W-1:0]),
    .wdata(rows.adjacency_row),
    .re   (row_re),
    .raddr(row_raddr),
    .rdata(row_rdata)
  );

  bpm_ram #(
    .WIDTH (STK_W),
    .DEPTH (bpm_pkg::STK_ENTRIES),
    .ADDR_W(bpm_pkg::STK_AW)
  ) u_search_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  bpm_col_scan u_col_scan (
    .adj        (row_rdata),
    .visited    (visited),
    .start      (top_next),
    .cols_in_use(cols_in_use),
    .res        (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    row_re     = 1'b0;
    row_raddr  = cur_row;
    stk_we     = 1'b0;
    stk_waddr  = bpm_pkg::STK_AW'(depth - 5'd1);
    stk_wdata  = {top_row, col_next};
    stk_re     = 1'b0;
    stk_raddr  = bpm_pkg::STK_AW'(depth - 5'd2);
    load_out   = 1'b0;
    unique case (state)
      bpm_pkg::ST_LOAD: begin
        if (row_accept && rows.row_last) begin
          state_next = (overflow || !room) ? bpm_pkg::ST_FINISH : bpm_pkg::ST_ROW_START;
        end
      end
      bpm_pkg::ST_ROW_START: begin
        row_re     = 1'b1;
        state_next = bpm_pkg::ST_SCAN;
      end
      bpm_pkg::ST_SCAN: begin
        if (!scan.found) begin
          if (depth == 5'd1) begin
            state_next = bpm_pkg::ST_FINISH;
          end else begin
            stk_re     = 1'b1;
            state_next = bpm_pkg::ST_POP_LOAD;
          end
        end else if (!owner_valid[scan.col]) begin
          if (depth == 5'd1) begin
            state_next = bpm_pkg::ST_ROW_DONE;
          end else begin
            stk_re     = 1'b1;
            state_next = bpm_pkg::ST_COMMIT;
          end
        end else if (depth < bpm_pkg::DEPTH_W'(bpm_pkg::STACK_DEPTH)) begin
          stk_we    = 1'b1;
          row_re    = 1'b1;
          row_raddr = owner[scan.col];
        end
      end
      bpm_pkg::ST_POP_LOAD: begin
        row_re     = 1'b1;
        row_raddr  = frame_row;
        state_next = bpm_pkg::ST_SCAN;
      end
      bpm_pkg::ST_COMMIT: begin
        if (commit_idx == '0) begin
          state_next = bpm_pkg::ST_ROW_DONE;
        end else begin
          stk_re    = 1'b1;
          stk_raddr = commit_idx - 1'b1;
        end
      end
      bpm_pkg::ST_ROW_DONE: begin
        state_next = last_row ? bpm_pkg::ST_FINISH : bpm_pkg::ST_ROW_START;
      end
      bpm_pkg::ST_FINISH: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = bpm_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = bpm_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= bpm_pkg::CFG_RESET;
      row_count   <= '0;
      overflow    <= 1'b0;
      owner_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        cols_in_use <= cfg.columns_in_use;
      end
      if (row_we) begin
        row_count <= row_count + CNT_W'(1);
      end else if (row_accept) begin
        overflow <= 1'b1;
      end
      if (state == bpm_pkg::ST_LOAD && row_accept && rows.row_last) begin
        owner_valid <= '0;
      end
      if (state == bpm_pkg::ST_SCAN && scan.found && !owner_valid[scan.col]) begin
        owner_valid[scan.col] <= 1'b1;
      end
      if (state == bpm_pkg::ST_COMMIT) begin
        owner_valid[frame_col] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        row_count <= '0;
        overflow  <= 1'b0;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bpm_pkg::ST_LOAD: begin
        cur_row     <= '0;
        res_all     <= 1'b0;
        res_matched <= '0;
        res_tmr     <= 1'b1;
      end
      bpm_pkg::ST_ROW_START: begin
        depth    <= 5'd1;
        top_row  <= cur_row;
        top_next <= '0;
        visited  <= '0;
      end
      bpm_pkg::ST_SCAN: begin
        res_tmr <= 1'b0;
        if (!scan.found) begin
          if (depth == 5'd1) begin
            res_all     <= 1'b0;
            res_matched <= cur_row6[bpm_pkg::MATCH_W-1:0];
          end else begin
            depth <= depth - 5'd1;
          end
        end else begin
          visited[scan.col] <= 1'b1;
          if (!owner_valid[scan.col]) begin
            top_next        <= col_next;
            owner[scan.col] <= top_row;
            commit_idx      <= bpm_pkg::STK_AW'(depth - 5'd2);
          end else if (depth < bpm_pkg::DEPTH_W'(bpm_pkg::STACK_DEPTH)) begin
            depth    <= depth + 5'd1;
            top_row  <= owner[scan.col];
            top_next <= '0;
          end else begin
            top_next <= col_next;
          end
        end
      end
      bpm_pkg::ST_POP_LOAD: begin
        top_row  <= frame_row;
        top_next <= frame_next;
      end
      bpm_pkg::ST_COMMIT: begin
        owner[frame_col] <= frame_row;
        commit_idx       <= commit_idx - 1'b1;
      end
      bpm_pkg::ST_ROW_DONE: begin
        cur_row     <= cur_row + 1'b1;
        res_all     <= 1'b1;
        res_matched <= row_count6[bpm_pkg::MATCH_W-1:0];
      end
      bpm_pkg::ST_FINISH: begin
        if (load_out) begin
          out_all     <= res_all;
          out_matched <= res_matched;
          out_tmr     <= res_tmr;
        end
      end
      default: begin
      end
    endcase
  end

  // Each completed augmentation adds exactly one owned column.
  assert property (@(posedge clk) disable iff (rst)
    state == bpm_pkg::ST_SCAN |-> $countones(owner_valid) == cur_row)
    else $error("owned column count does not match rows matched");

  assert property (@(posedge clk) disable iff (rst)
    state == bpm_pkg::ST_SCAN |->
      (depth != '0) && (depth <= bpm_pkg::DEPTH_W'(bpm_pkg::STACK_DEPTH)))
    else $error("search depth out of range");

  assert property (@(posedge clk) disable iff (rst)
    row_count <= CNT_W'(MAX_SIZE))
    else $error("row count exceeds row store depth");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bpm_pkg::ST_FINISH)
    else $error("result item raised outside of finish");

endmodule
`default_nettype wire

@@ test/bpm_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bipartite matching check scoreboard
// Watches the row, result and configuration channels, works out the matching
// verdict of each completed row set and compares it with the block's result.
// ----------------------------------------------------------------------------
module bpm_match_checker #(
  parameter int MAX_SIZE = bpm_pkg::MAX_SIZE_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        row_valid,
  input  wire logic                        row_ready,
  input  wire logic [bpm_pkg::ROW_W-1:0]   adjacency_row,
  input  wire logic                        row_last,
  input  wire logic                        result_valid,
  input  wire logic                        result_ready,
  input  wire logic                        all_matched,
  input  wire logic [bpm_pkg::MATCH_W-1:0] rows_matched,
  input  wire logic                        too_many_rows,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [bpm_pkg::CFG_W-1:0]   cfg_columns,
  output int                               mismatch_count,
  output int                               verdicts_pending
);

  localparam int UNOWNED = -1;

  typedef struct packed {
    logic                        all_matched;
    logic [bpm_pkg::MATCH_W-1:0] rows_matched;
    logic                        too_many_rows;
  } verdict_t;

  logic [bpm_pkg::CFG_W-1:0] columns;
  logic [bpm_pkg::ROW_W-1:0] set_rows [MAX_SIZE];
  int                        set_count;
  logic                      set_overflow;
  verdict_t                  expected_verdicts [$];
  int                        mismatches = 0;

  task automatic report(input string line);
    $display("%0t ns: %s", $time, line);
    mismatches++;
  endtask

  // Kuhn matching in arrival order, lowest column first, with an explicit
  // frame stack in place of recursion.
  function automatic verdict_t match_set();
    int                           owner [bpm_pkg::NUM_COLS];
    int                           frame_row [bpm_pkg::STACK_DEPTH];
    int                           frame_next [bpm_pkg::STACK_DEPTH];
    int                           frame_col [bpm_pkg::STACK_DEPTH];
    logic [bpm_pkg::NUM_COLS-1:0] usable;
    logic [bpm_pkg::NUM_COLS-1:0] visited;
    logic [bpm_pkg::NUM_COLS-1:0] adj;
    logic [31:0]                  span;
    int                           depth;
    int                           col;
    int                           r;
    int                           i;
    logic                         placed;
    verdict_t                     v;

    v = '0;
    if (set_overflow) begin
      v.too_many_rows = 1'b1;
      return v;
    end
    span = (32'd1 << columns) - 32'd1;
    usable = (columns >= bpm_pkg::NUM_COLS) ? '1 : span[bpm_pkg::NUM_COLS-1:0];
    for (i = 0; i < bpm_pkg::NUM_COLS; i++) begin
      owner[i] = UNOWNED;
    end
    v.all_matched = 1'b1;
    for (r = 0; r < set_count; r++) begin
      visited = '0;
      placed = 1'b0;
      depth = 1;
      frame_row[0] = r;
      frame_next[0] = 0;
      frame_col[0] = 0;
      while (depth > 0 && !placed) begin
        adj = set_rows[frame_row[depth-1]] & usable;
        col = frame_next[depth-1];
        while (col < bpm_pkg::NUM_COLS && (!adj[col] || visited[col])) begin
          col++;
        end
        if (col >= bpm_pkg::NUM_COLS) begin
          depth--;
        end else begin
          visited[col] = 1'b1;
          frame_next[depth-1] = col + 1;
          frame_col[depth-1] = col;
          if (owner[col] == UNOWNED) begin
            for (i = 0; i < depth; i++) begin
              owner[frame_col[i]] = frame_row[i];
            end
            placed = 1'b1;
          end else if (depth < bpm_pkg::STACK_DEPTH) begin
            frame_row[depth] = owner[col];
            frame_next[depth] = 0;
            frame_col[depth] = 0;
            depth++;
          end
        end
      end
      if (!placed) begin
        v.all_matched = 1'b0;
        break;
      end
      v.rows_matched = v.rows_matched + 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t seen;
    verdict_t want;

    if (rst) begin
      columns = bpm_pkg::CFG_RESET;
      set_count = 0;
      set_overflow = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        columns = cfg_columns;
      end
      if (row_valid && row_ready) begin
        if (set_count < MAX_SIZE) begin
          set_rows[set_count] = adjacency_row;
          set_count++;
        end else begin
          set_overflow = 1'b1;
        end
        if (row_last) begin
          expected_verdicts.push_back(match_set());
          set_count = 0;
          set_overflow = 1'b0;
        end
      end
      if (result_valid && result_ready) begin
        seen = {all_matched, rows_matched, too_many_rows};
        if (expected_verdicts.size() == 0) begin
          report($sformatf("result item with no row set outstanding (%b)", seen));
        end else begin
          want = expected_verdicts.pop_front();
          if (seen.all_matched !== want.all_matched) begin
            report($sformatf("all_matched %b, expected %b",
                             seen.all_matched, want.all_matched));
          end
          if (seen.rows_matched !== want.rows_matched) begin
            report($sformatf("rows_matched %0d, expected %0d",
                             seen.rows_matched, want.rows_matched));
          end
          if (seen.too_many_rows !== want.too_many_rows) begin
            report($sformatf("too_many_rows %b, expected %b",
                             seen.too_many_rows, want.too_many_rows));
          end
        end
      end
    end
    mismatch_count <= mismatches;
    verdicts_pending <= expected_verdicts.size();
  end

endmodule

@@ test/tb_bipartite_perfect_matching_check_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bipartite perfect matching check unit testbench
// Sends directed and random adjacency row sets under several column counts,
// with random gaps on the row side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_bipartite_perfect_matching_check_unit;

  localparam int SET_LIMIT  = bpm_pkg::MAX_SIZE_DEFAULT;
  localparam int ROW_TARGET = 500;
  localparam int PHASES     = 8;

  typedef enum int {
    FILL_PERMUTED,
    FILL_SPARSE,
    FILL_DENSE,
    FILL_CHAIN
  } fill_t;

  logic clk = 1'b0;
  logic rst;
  bit   idling;
  bit   row_gaps;
  int   rows_sent;
  int   mismatch_count;
  int   verdicts_pending;

  bpm_row_if    row_ch ();
  bpm_result_if res_ch ();
  bpm_cfg_if    cfg_ch ();

  bipartite_perfect_matching_check_unit #(
    .MAX_SIZE(SET_LIMIT)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .rows   (row_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  bpm_match_checker #(
    .MAX_SIZE(SET_LIMIT)
  ) i_match_checker (
    .clk              (clk),
    .rst              (rst),
    .row_valid        (row_ch.valid),
    .row_ready        (row_ch.ready),
    .adjacency_row    (row_ch.adjacency_row),
    .row_last         (row_ch.row_last),
    .result_valid     (res_ch.valid),
    .result_ready     (res_ch.ready),
    .all_matched      (res_ch.all_matched),
    .rows_matched     (res_ch.rows_matched),
    .too_many_rows    (res_ch.too_many_rows),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_columns      (cfg_ch.columns_in_use),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending)
  );

  always #6 clk = ~clk;

  function automatic logic [bpm_pkg::ROW_W-1:0] rand_row();
    logic [31:0] word;

    word = $urandom;
    return word[bpm_pkg::ROW_W-1:0];
  endfunction

  task automatic send_row(input logic [bpm_pkg::ROW_W-1:0] bits, input logic last);
    if (idling && row_gaps && $urandom_range(0, 5) == 0) begin
      row_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    row_ch.valid <= 1'b1;
    row_ch.adjacency_row <= bits;
    row_ch.row_last <= last;
    @(posedge clk);
    while (!row_ch.ready) @(posedge clk);
    rows_sent++;
  endtask

  task automatic write_columns(input logic [bpm_pkg::CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.columns_in_use <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    row_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_random_set();
    int                        n;
    int                        i;
    int                        j;
    int                        tmp;
    int                        base;
    int                        perm [bpm_pkg::NUM_COLS];
    fill_t                     fill;
    logic [bpm_pkg::ROW_W-1:0] bits;

    row_gaps = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 24) == 0) begin
      n = $urandom_range(SET_LIMIT + 1, SET_LIMIT + 4);
    end else if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(7, SET_LIMIT);
    end else begin
      n = $urandom_range(1, 6);
    end
    fill = fill_t'($urandom_range(0, 3));
    for (i = 0; i < bpm_pkg::NUM_COLS; i++) begin
      perm[i] = i;
    end
    for (i = bpm_pkg::NUM_COLS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    base = $urandom_range(0, bpm_pkg::NUM_COLS - 1);
    for (i = 0; i < n; i++) begin
      bits = '0;
      case (fill)
        FILL_PERMUTED: begin
          bits = rand_row() & rand_row() & rand_row();
          bits[perm[i % bpm_pkg::NUM_COLS]] = 1'b1;
        end
        FILL_SPARSE: begin
          repeat ($urandom_range(1, 3)) begin
            bits[$urandom_range(0, bpm_pkg::NUM_COLS - 1)] = 1'b1;
          end
        end
        FILL_DENSE: begin
          bits = rand_row();
        end
        default: begin
          if (i == n - 1) begin
            bits[base] = 1'b1;
          end else begin
            bits[(base + i) % bpm_pkg::NUM_COLS] = 1'b1;
            bits[(base + i + 1) % bpm_pkg::NUM_COLS] = 1'b1;
          end
        end
      endcase
      send_row(bits, i == n - 1);
    end
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      case ($urandom_range(0, 9))
        0, 1: begin
          if (idling) begin
            res_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
          end
        end
        2: begin
          res_ch.ready <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
        default: ;
      endcase
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int phase;
    int goal;

    rst <= 1'b1;
    idling = 1'b1;
    row_gaps = 1'b1;
    rows_sent = 0;
    row_ch.valid <= 1'b0;
    row_ch.adjacency_row <= '0;
    row_ch.row_last <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.columns_in_use <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default column count: full row, empty row, only ignored high bits,
    // two rows fighting over one column, and a short augmenting chain.
    send_row(16'hFFFF, 1'b1);
    send_row(16'h0000, 1'b1);
    send_row(16'hC000, 1'b1);
    send_row(16'h0001, 1'b0);
    send_row(16'h0001, 1'b1);
    send_row(16'h0003, 1'b0);
    send_row(16'h0006, 1'b0);
    send_row(16'h0001, 1'b1);
    wait_drained();
    write_columns(5'd16);
    send_row(16'h8000, 1'b1);
    wait_drained();
    write_columns(5'd0);
    send_row(16'hFFFF, 1'b1);
    wait_drained();
    write_columns(5'd1);
    send_row(16'hFFFE, 1'b1);
    wait_drained();
    // Column count above the column total, then a set with one row too many.
    write_columns(5'd31);
    repeat (SET_LIMIT) send_row(16'hFFFF, 1'b0);
    send_row(16'hFFFF, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: write_columns(5'd16);
        1: write_columns(5'($urandom_range(1, 15)));
        2: write_columns(5'd31);
        3: write_columns(5'($urandom_range(17, 30)));
        4: write_columns(5'd0);
        5: write_columns(bpm_pkg::CFG_RESET);
        6: write_columns(5'($urandom_range(1, 16)));
        default: write_columns(5'd16);
      endcase
      if (phase == PHASES - 1) begin
        idling = 1'b0;
      end
      goal = rows_sent + ROW_TARGET / PHASES;
      while (rows_sent < goal) send_random_set();
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
